@@ hdl/wwmc_pkg.sv @@
// ----------------------------------------------------------------------------
// wwmc_pkg
// Shared types, codes and helpers for the whole-word match counter.
// ----------------------------------------------------------------------------
package wwmc_pkg;

    // input item kinds
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // result types
    localparam logic RES_MATCH   = 1'b0;
    localparam logic RES_SUMMARY = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

    localparam int PAT_BYTES = 16;
    localparam int CFG_W     = 64;
    localparam int PLEN_W    = 5;
    localparam int WORD_W    = 9;
    localparam int LINE_W    = 32;
    localparam int LONG_W    = 10;
    localparam logic [LONG_W-1:0] LONG_MAX = '1;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_QUEST   = 8'h3f;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    typedef struct packed {
        logic [PAT_BYTES*8-1:0] pattern;
        logic [PLEN_W-1:0]      length;
    } cfg_t;

    typedef struct packed {
        logic              result_type;
        logic [LINE_W-1:0] line_number;
        logic [WORD_W-1:0] word_number;
        logic [LONG_W-1:0] longest_length;
        logic [LINE_W-1:0] line_count;
        logic [LINE_W-1:0] match_count;
        logic              last;
    } result_t;

    function automatic logic is_delim(input logic [7:0] b);
        return b == CH_BANG || b == CH_SPACE || b == CH_DOT || b == CH_QUEST ||
               b == CH_SEMI || b == CH_QUOTE || b == CH_COMMA || b == CH_NEWLINE;
    endfunction

    function automatic logic [LINE_W-1:0] sat_inc32(input logic [LINE_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [WORD_W-1:0] sat_inc_word(input logic [WORD_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

@@ hdl/wwmc_scan.sv @@
// ----------------------------------------------------------------------------
// wwmc_scan
// Token and line tracker: updates stream state for one item per cycle while
// accept is high and produces up to two result items for the queue.
// ----------------------------------------------------------------------------
module wwmc_scan #(
    parameter int LINE_LIMIT  = 1023,
    parameter int MAX_PATTERN = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              kind,
    input  logic [7:0]        text_byte,
    input  wwmc_pkg::cfg_t    cfg,
    output wwmc_pkg::result_t res0,
    output wwmc_pkg::result_t res1,
    output logic [1:0]        push_cnt
);

    localparam int LEN_W = $clog2(LINE_LIMIT + 1);
    localparam int POS_W = $clog2(MAX_PATTERN + 1);

    logic [LEN_W-1:0]            line_len_reg, line_len_next;
    logic [LEN_W-1:0]            longest_reg, longest_next;
    logic [wwmc_pkg::LINE_W-1:0] line_reg, line_next;
    logic [wwmc_pkg::LINE_W-1:0] matches_reg, matches_next;
    logic [wwmc_pkg::WORD_W-1:0] word_reg, word_next;
    logic                        inside_reg, inside_next;
    logic                        equal_reg, equal_next;
    logic [POS_W-1:0]            pos_reg, pos_next;

    logic [LEN_W-1:0]            len_inc;
    logic [LEN_W-1:0]            longest_f;
    logic [wwmc_pkg::LINE_W-1:0] lines_f, matches_f;
    logic [wwmc_pkg::WORD_W-1:0] word_f;
    logic [POS_W-1:0]            base_pos, pos_t;
    logic                        base_eq, eq_t, inside_pre;
    logic                        delim, end_line, fin, hit, has_line;
    logic [3:0]                  byte_idx;
    logic [7:0]                  pat_byte;
    wwmc_pkg::result_t           match_res, summary_res;

    function automatic logic match_ok(input logic [POS_W-1:0] pos, input logic eq,
                                      input logic [wwmc_pkg::PLEN_W-1:0] plen);
        return eq && plen != '0 && plen <= wwmc_pkg::PLEN_W'(MAX_PATTERN) &&
               wwmc_pkg::PLEN_W'(pos) == plen;
    endfunction

    always_comb begin
        // token state after this byte, before any token close
        len_inc  = line_len_reg + 1'b1;
        delim    = wwmc_pkg::is_delim(text_byte);
        base_pos = inside_reg ? pos_reg : '0;
        base_eq  = inside_reg ? equal_reg : 1'b1;
        byte_idx = 4'(base_pos);
        pat_byte = cfg.pattern[{byte_idx, 3'b000} +: 8];
        if (delim) begin
            inside_pre = inside_reg;
            pos_t      = pos_reg;
            eq_t       = equal_reg;
        end else begin
            inside_pre = 1'b1;
            pos_t      = base_pos;
            eq_t       = base_eq;
            if (base_eq) begin
                if (wwmc_pkg::PLEN_W'(base_pos) < cfg.length &&
                    32'(base_pos) < MAX_PATTERN && text_byte == pat_byte) begin
                    pos_t = base_pos + 1'b1;
                end else begin
                    eq_t = 1'b0;
                end
            end
        end
        end_line = text_byte == wwmc_pkg::CH_NEWLINE || len_inc >= LEN_W'(LINE_LIMIT);
        has_line = line_len_reg != '0;

        if (kind == wwmc_pkg::KIND_END) begin
            fin = has_line && inside_reg;
            hit = fin && match_ok(pos_reg, equal_reg, cfg.length);
        end else begin
            fin = inside_pre && (delim || end_line);
            hit = fin && match_ok(pos_t, eq_t, cfg.length);
        end

        word_f    = fin ? wwmc_pkg::sat_inc_word(word_reg) : word_reg;
        matches_f = hit ? wwmc_pkg::sat_inc32(matches_reg) : matches_reg;
        if (kind == wwmc_pkg::KIND_END) begin
            lines_f   = has_line ? wwmc_pkg::sat_inc32(line_reg) : line_reg;
            longest_f = (has_line && line_len_reg > longest_reg) ? line_len_reg : longest_reg;
        end else begin
            lines_f   = end_line ? wwmc_pkg::sat_inc32(line_reg) : line_reg;
            longest_f = (end_line && len_inc > longest_reg) ? len_inc : longest_reg;
        end

        match_res                = '0;
        match_res.result_type    = wwmc_pkg::RES_MATCH;
        match_res.line_number    = line_reg;
        match_res.word_number    = word_reg;
        match_res.last           = kind == wwmc_pkg::KIND_TEXT;

        summary_res              = '0;
        summary_res.result_type  = wwmc_pkg::RES_SUMMARY;
        summary_res.line_count   = lines_f;
        summary_res.match_count  = matches_f;
        summary_res.last         = 1'b1;
        if (32'(longest_f) > 32'(wwmc_pkg::LONG_MAX)) begin
            summary_res.longest_length = wwmc_pkg::LONG_MAX;
        end else begin
            summary_res.longest_length = wwmc_pkg::LONG_W'(longest_f);
        end

        res0     = match_res;
        res1     = summary_res;
        push_cnt = 2'd0;
        if (accept) begin
            if (kind == wwmc_pkg::KIND_END) begin
                if (hit) begin
                    push_cnt = 2'd2;
                end else begin
                    res0     = summary_res;
                    push_cnt = 2'd1;
                end
            end else if (hit) begin
                push_cnt = 2'd1;
            end
        end

        line_len_next = line_len_reg;
        longest_next  = longest_reg;
        line_next     = line_reg;
        matches_next  = matches_reg;
        word_next     = word_reg;
        inside_next   = inside_reg;
        equal_next    = equal_reg;
        pos_next      = pos_reg;
        if (accept) begin
            if (kind == wwmc_pkg::KIND_END) begin
                // stream closes, back to the reset state
                line_len_next = '0;
                longest_next  = '0;
                line_next     = '0;
                matches_next  = '0;
                word_next     = '0;
                inside_next   = 1'b0;
                equal_next    = 1'b1;
                pos_next      = '0;
            end else begin
                line_len_next = end_line ? '0 : len_inc;
                longest_next  = longest_f;
                line_next     = lines_f;
                matches_next  = matches_f;
                word_next     = end_line ? '0 : word_f;
                inside_next   = inside_pre && !fin;
                equal_next    = eq_t;
                pos_next      = pos_t;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_len_reg <= '0;
            longest_reg  <= '0;
            line_reg     <= '0;
            matches_reg  <= '0;
            word_reg     <= '0;
            inside_reg   <= 1'b0;
            equal_reg    <= 1'b1;
            pos_reg      <= '0;
        end else begin
            line_len_reg <= line_len_next;
            longest_reg  <= longest_next;
            line_reg     <= line_next;
            matches_reg  <= matches_next;
            word_reg     <= word_next;
            inside_reg   <= inside_next;
            equal_reg    <= equal_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

@@ hdl/wwmc_fifo.sv @@
// ----------------------------------------------------------------------------
// wwmc_fifo
// Four-entry result queue taking up to two items per cycle and giving one.
// ----------------------------------------------------------------------------
module wwmc_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_cnt,
    input  wwmc_pkg::result_t in0,
    input  wwmc_pkg::result_t in1,
    output logic              room,
    output wwmc_pkg::result_t out_item,
    output logic              out_valid,
    input  logic              out_ready
);

    wwmc_pkg::result_t                entry_reg [wwmc_pkg::FIFO_DEPTH];
    logic [wwmc_pkg::FIFO_PTR_W-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next, wptr_1;
    logic [wwmc_pkg::FIFO_CNT_W-1:0] count_reg, count_next, count_after_pop;
    logic                             pop;

    always_comb begin
        pop             = out_valid && out_ready;
        count_after_pop = count_reg - wwmc_pkg::FIFO_CNT_W'(pop);
        // room for the two results an end item can give
        room            = count_after_pop <= wwmc_pkg::FIFO_CNT_W'(wwmc_pkg::FIFO_DEPTH - 2);
        count_next      = count_after_pop + wwmc_pkg::FIFO_CNT_W'(push_cnt);
        wptr_1          = wptr_reg + 1'b1;
        wptr_next       = wptr_reg + wwmc_pkg::FIFO_PTR_W'(push_cnt);
        rptr_next       = rptr_reg + wwmc_pkg::FIFO_PTR_W'(pop);
        out_valid       = count_reg != '0;
        out_item        = entry_reg[rptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entry_reg[wptr_reg] <= in0;
        end
        if (push_cnt == 2'd2) begin
            entry_reg[wptr_1] <= in1;
        end
    end

endmodule

@@ hdl/whole_word_match_counter_top.sv @@
// ----------------------------------------------------------------------------
// whole_word_match_counter_top
// Whole-word pattern search over a byte stream with line and match counting.
// ----------------------------------------------------------------------------
// One text byte or end item is taken every clock while s_ready is high; the
// token and line state updates in the cycle the item is accepted and its
// results (at most one for a text byte, one or two for an end item) enter a
// four-entry result queue whose registered entries and count drive m_valid.
// s_ready drops only while that queue could not hold two more results, when
// the result side stalls or two-result end items outpace its drain. The user
// must write pattern registers through the cfg port while idle; unchecked.
module whole_word_match_counter_top #(
    parameter int LINE_LIMIT  = 1023,
    parameter int MAX_PATTERN = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [wwmc_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [7:0]                    s_text_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_result_type,
    output logic [wwmc_pkg::LINE_W-1:0]   m_line_number,
    output logic [wwmc_pkg::WORD_W-1:0]   m_word_number,
    output logic [wwmc_pkg::LONG_W-1:0]   m_longest_length,
    output logic [wwmc_pkg::LINE_W-1:0]   m_line_count,
    output logic [wwmc_pkg::LINE_W-1:0]   m_match_count,
    output logic                          m_last
);

    logic [wwmc_pkg::CFG_W-1:0]  pat_low_reg, pat_high_reg;
    logic [wwmc_pkg::PLEN_W-1:0] pat_len_reg;
    wwmc_pkg::cfg_t              cfg;
    wwmc_pkg::result_t           res0, res1, head;
    logic [1:0]                  push_cnt;
    logic                        accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                wwmc_pkg::REG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                wwmc_pkg::REG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                wwmc_pkg::REG_PATTERN_LENGTH: pat_len_reg  <= cfg_data[wwmc_pkg::PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.pattern = {pat_high_reg, pat_low_reg};
    assign cfg.length  = pat_len_reg;
    assign accept      = s_valid && s_ready;

    wwmc_scan #(
        .LINE_LIMIT  (LINE_LIMIT),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .kind      (s_kind),
        .text_byte (s_text_byte),
        .cfg       (cfg),
        .res0      (res0),
        .res1      (res1),
        .push_cnt  (push_cnt)
    );

    wwmc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .in0       (res0),
        .in1       (res1),
        .room      (s_ready),
        .out_item  (head),
        .out_valid (m_valid),
        .out_ready (m_ready)
    );

    assign m_result_type    = head.result_type;
    assign m_line_number    = head.line_number;
    assign m_word_number    = head.word_number;
    assign m_longest_length = head.longest_length;
    assign m_line_count     = head.line_count;
    assign m_match_count    = head.match_count;
    assign m_last           = head.last;

endmodule

@@ hdl/wwmc_checker.sv @@
// ----------------------------------------------------------------------------
// wwmc_checker
// Port-level checks for the whole-word match counter, bound to the top level.
// ----------------------------------------------------------------------------
module wwmc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_result_type,
    input logic [wwmc_pkg::LINE_W-1:0] m_line_number,
    input logic [wwmc_pkg::WORD_W-1:0] m_word_number,
    input logic [wwmc_pkg::LONG_W-1:0] m_longest_length,
    input logic [wwmc_pkg::LINE_W-1:0] m_line_count,
    input logic [wwmc_pkg::LINE_W-1:0] m_match_count,
    input logic                        m_last
);

    // queue empties on reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_type) &&
        $stable(m_line_number) && $stable(m_word_number) && $stable(m_line_count) &&
        $stable(m_match_count) && $stable(m_longest_length) && $stable(m_last))
        else $error("stalled result item changed");

    // a summary always closes the results of its item
    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_type == wwmc_pkg::RES_SUMMARY |-> m_last)
        else $error("summary without last");

    a_match_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_type == wwmc_pkg::RES_MATCH |->
        m_longest_length == '0 && m_line_count == '0 && m_match_count == '0)
        else $error("match report carries summary fields");

endmodule

bind whole_word_match_counter_top wwmc_checker u_wwmc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_result_type    (m_result_type),
    .m_line_number    (m_line_number),
    .m_word_number    (m_word_number),
    .m_longest_length (m_longest_length),
    .m_line_count     (m_line_count),
    .m_match_count    (m_match_count),
    .m_last           (m_last)
);
